// ----- rtl/fp8c_pkg.sv -----
package fp8c_pkg;

  typedef enum logic [2:0] {
    FMT_E4M3FN   = 3'd0,
    FMT_E4M3FNUZ = 3'd1,
    FMT_E5M2     = 3'd2,
    FMT_E5M2FNUZ = 3'd3,
    FMT_E8M0     = 3'd4
  } fmt_e;

  localparam logic [7:0] FNUZ_NAN  = 8'h80;
  localparam logic [7:0] E8M0_NAN  = 8'hFF;
  localparam logic [7:0] E8M0_MAX  = 8'hFE;

  // Per-format constants of the 8-bit targets.
  typedef struct packed {
    logic        mbits3;     // 3 mantissa bits, else 2
    logic [7:0]  exp_off;    // binary32 exponent that maps to a biased exponent of zero
    logic [7:0]  esub_min;   // smallest binary32 exponent that can round to nonzero
    logic [7:0]  emax;       // largest binary32 exponent with a finite encoding
    logic [6:0]  max_mag;    // largest finite magnitude code
    logic [30:0] ovf_thr;    // magnitude bits of the largest finite value
    logic        fnuz;
    logic [6:0]  nan_mag;
    logic [6:0]  ovf_mag;    // code for overflow without saturation
  } fmt_param_t;

  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        big;
    logic [4:0]  exp_field;
    logic [23:0] shifted;
    logic        lost;
    logic        mag_gt;
    fmt_e        fmt;
    logic        sat;
    logic [7:0]  e8m0;
  } s1_t;

  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic [6:0]  mag;
    logic        mag_gt;
    fmt_e        fmt;
    logic        sat;
    logic [7:0]  e8m0;
  } s2_t;

  function automatic fmt_param_t fmt_param(input fmt_e fmt);
    fmt_param_t p;
    unique case (fmt)
      FMT_E4M3FNUZ: p = '{1'b1, 8'd119, 8'd116, 8'd134, 7'h7F, 31'h43700000,
                          1'b1, 7'h7F, 7'h7F};
      FMT_E5M2:     p = '{1'b0, 8'd112, 8'd110, 8'd142, 7'h7B, 31'h47600000,
                          1'b0, 7'h7E, 7'h7C};
      FMT_E5M2FNUZ: p = '{1'b0, 8'd111, 8'd109, 8'd142, 7'h7F, 31'h47600000,
                          1'b1, 7'h7F, 7'h7F};
      default:      p = '{1'b1, 8'd120, 8'd117, 8'd135, 7'h7E, 31'h43E00000,
                          1'b0, 7'h7F, 7'h7F};
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/fp8c_align.sv -----
module fp8c_align (
  input  logic [31:0]         float_bits_i,
  input  fp8c_pkg::fmt_e      fmt_i,
  input  logic                sat_i,
  output fp8c_pkg::s1_t       s1_o
);

  fp8c_pkg::fmt_param_t p;
  logic [7:0]  e;
  logic [22:0] m;
  logic        m_nz;
  logic        special;
  logic        big;
  logic        norm;
  logic        sub;
  logic [7:0]  exp_diff;
  logic [7:0]  sh_full;
  logic [2:0]  sh;
  logic [27:0] ext;
  logic [8:0]  e8_sum;

  always_comb begin
    p        = fp8c_pkg::fmt_param(fmt_i);
    e        = float_bits_i[30:23];
    m        = float_bits_i[22:0];
    m_nz     = (m != 23'd0);
    special  = (e == 8'hFF);
    big      = !special && (e > p.emax);
    norm     = !special && !big && (e > p.exp_off);
    sub      = !special && !big && !norm && (e >= p.esub_min);
    exp_diff = e - p.exp_off;
    sh_full  = p.exp_off + 8'd1 - e;
    sh       = norm ? 3'd0 : sh_full[2:0];
    // Four guard positions below the significand catch the bits shifted out.
    ext      = {1'b1, m, 4'b0000} >> sh;

    s1_o.sign      = float_bits_i[31];
    s1_o.is_nan    = special && m_nz;
    s1_o.is_inf    = special && !m_nz;
    s1_o.big       = big;
    s1_o.exp_field = norm ? exp_diff[4:0] : 5'd0;
    s1_o.shifted   = (norm || sub) ? ext[27:4] : 24'd0;
    s1_o.lost      = sub && (ext[3:0] != 4'd0);
    s1_o.mag_gt    = float_bits_i[30:0] > p.ovf_thr;
    s1_o.fmt       = fmt_i;
    s1_o.sat       = sat_i;

    e8_sum = {1'b0, e} + {8'd0, m_nz};
    if (special && m_nz) begin
      s1_o.e8m0 = fp8c_pkg::E8M0_NAN;
    end else if (float_bits_i[31]) begin
      s1_o.e8m0 = fp8c_pkg::E8M0_NAN;
    end else if (special) begin
      s1_o.e8m0 = fp8c_pkg::E8M0_MAX;
    end else if (e == 8'd0) begin
      s1_o.e8m0 = 8'd0;
    end else if (e8_sum >= 9'd255) begin
      s1_o.e8m0 = fp8c_pkg::E8M0_MAX;
    end else begin
      s1_o.e8m0 = e8_sum[7:0];
    end
  end

endmodule

// ----- rtl/fp8c_round.sv -----
module fp8c_round (
  input  fp8c_pkg::s1_t s1_i,
  output fp8c_pkg::s2_t s2_o
);

  fp8c_pkg::fmt_param_t p;
  logic [6:0] pre;
  logic       guard;
  logic       sticky;
  logic       rnd;
  logic [7:0] sum;

  always_comb begin
    p = fp8c_pkg::fmt_param(s1_i.fmt);
    if (p.mbits3) begin
      pre    = {s1_i.exp_field[3:0], s1_i.shifted[22:20]};
      guard  = s1_i.shifted[19];
      sticky = s1_i.lost || (s1_i.shifted[18:0] != 19'd0);
    end else begin
      pre    = {s1_i.exp_field, s1_i.shifted[22:21]};
      guard  = s1_i.shifted[20];
      sticky = s1_i.lost || (s1_i.shifted[19:0] != 20'd0);
    end
    // Round to nearest, ties to even; a carry may move into the exponent field.
    rnd = guard && (pre[0] || sticky);
    sum = {1'b0, pre} + {7'd0, rnd};

    s2_o.sign   = s1_i.sign;
    s2_o.is_nan = s1_i.is_nan;
    s2_o.is_inf = s1_i.is_inf;
    if (s1_i.big || (sum > {1'b0, p.max_mag})) begin
      s2_o.mag = p.max_mag;
    end else begin
      s2_o.mag = sum[6:0];
    end
    s2_o.mag_gt = s1_i.mag_gt;
    s2_o.fmt    = s1_i.fmt;
    s2_o.sat    = s1_i.sat;
    s2_o.e8m0   = s1_i.e8m0;
  end

endmodule

// ----- rtl/fp8c_pack.sv -----
module fp8c_pack (
  input  fp8c_pkg::s2_t s2_i,
  output logic [7:0]    code_o
);

  fp8c_pkg::fmt_param_t p;
  logic                 ovf;

  always_comb begin
    p   = fp8c_pkg::fmt_param(s2_i.fmt);
    ovf = s2_i.is_inf ||
          (!s2_i.sat && (s2_i.mag == p.max_mag) && s2_i.mag_gt);
    case (s2_i.fmt) inside
      fp8c_pkg::FMT_E8M0: begin
        code_o = s2_i.e8m0;
      end
      fp8c_pkg::FMT_E4M3FN, fp8c_pkg::FMT_E4M3FNUZ,
      fp8c_pkg::FMT_E5M2, fp8c_pkg::FMT_E5M2FNUZ: begin
        if (s2_i.is_nan) begin
          code_o = p.fnuz ? fp8c_pkg::FNUZ_NAN : {s2_i.sign, p.nan_mag};
        end else if (s2_i.is_inf && s2_i.sat) begin
          code_o = {s2_i.sign, p.max_mag};
        end else if (ovf) begin
          code_o = p.fnuz ? fp8c_pkg::FNUZ_NAN : {s2_i.sign, p.ovf_mag};
        end else if (p.fnuz && (s2_i.mag == 7'd0)) begin
          // The unsigned-zero formats have no negative zero.
          code_o = 8'd0;
        end else begin
          code_o = {s2_i.sign, s2_i.mag};
        end
      end
      default: begin
        code_o = 8'd0;
      end
    endcase
  end

endmodule

// ----- rtl/float32_to_float8_cast.sv -----
// Channel   Dir  Payload                        Handshake
// s_axis    in   tdata[31:0] float_bits          tvalid/tready
// m_axis    out  tdata[7:0]  fp8_code            tvalid/tready
// apb       in   reg 0 target_format @0x0,      psel/penable/pwrite, pready
//                reg 1 saturate_enable @0x4
//
// One beat is taken every cycle while the pipeline advances; each beat passes
// through the align, round and pack register stages in that order.
// The whole pipeline advances together whenever the output register is empty
// or being drained, so a stall on m_axis holds every stage in place.
// Reset clears the stage valid bits and sets E4M3FN with saturation.
module float32_to_float8_cast (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] float_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] fp8_code
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_SAT    = 1'b1;

  fp8c_pkg::fmt_e fmt_q;
  logic           sat_q;
  logic           cfg_wr;

  logic           adv;
  fp8c_pkg::s1_t  s1_d, s1_q;
  fp8c_pkg::s2_t  s2_d, s2_q;
  logic           s1_vld_q, s2_vld_q, out_vld_q;
  logic [7:0]     code_d, code_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SAT) ? {31'd0, sat_q} : {29'd0, fmt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= fp8c_pkg::FMT_E4M3FN;
      sat_q <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FORMAT) begin
        fmt_q <= fp8c_pkg::fmt_e'(pwdata[2:0]);
      end else begin
        sat_q <= pwdata[0];
      end
    end
  end

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = code_q;

  fp8c_align u_align (
    .float_bits_i (s_axis_tdata),
    .fmt_i        (fmt_q),
    .sat_i        (sat_q),
    .s1_o         (s1_d)
  );

  fp8c_round u_round (
    .s1_i (s1_q),
    .s2_o (s2_d)
  );

  fp8c_pack u_pack (
    .s2_i   (s2_q),
    .code_o (code_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= s_axis_tvalid;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      code_q <= code_d;
    end
  end

  // A held stage keeps its beat until the pipeline moves again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && s2_vld_q) |=> (s2_vld_q && $stable(s2_q)))
    else $error("stage two beat changed during a stall");

  // Rounding and clamping never leave the finite range of the format.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (s2_q.mag <= fp8c_pkg::fmt_param(s2_q.fmt).max_mag))
    else $error("rounded magnitude above the largest finite value");

  // With saturation on, E4M3FN gives its NaN code only for a NaN input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_q.sat && (s2_q.fmt == fp8c_pkg::FMT_E4M3FN) && !s2_q.is_nan)
      |-> (code_d[6:0] != 7'h7F))
    else $error("saturating E4M3FN produced NaN");

endmodule
